### design/assert_macros.svh
// Assertion macros used by occupancy_grid_ray_update.
// Needs signals clk and rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// prop must hold at every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// cond must never be true at a clock edge outside reset
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### design/ogru_pkg.sv
// Package for the occupancy grid ray update block: widths, codes, FSM types.
// No dependencies.
package ogru_pkg;

  localparam int GRID_W_DEF = 640;
  localparam int GRID_H_DEF = 480;

  localparam int COORD_W = 12;
  localparam int CELL_W  = 4;
  localparam int WALK_W  = 13;
  localparam int CMD_W   = 2;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [CELL_W-1:0]         cell_t;
  typedef logic [WALK_W-1:0]         walk_t;
  typedef logic [CMD_W-1:0]          cmd_t;

  localparam cmd_t CMD_TRACE = 2'd0;
  localparam cmd_t CMD_READ  = 2'd1;
  localparam cmd_t CMD_WRITE = 2'd2;

  localparam cell_t CELL_RESET     = 4'd5;
  localparam cell_t CELL_PROTECTED = 4'd15;
  localparam cell_t MARK_ADD       = 4'd3;
  localparam cell_t MARK_CAP       = 4'd10;

  localparam walk_t MAX_WALK = 13'd4096;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADDR,
    ST_ACCESS,
    ST_UPDATE,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    PH_TRACE,
    PH_MARK,
    PH_READ,
    PH_WRITE
  } phase_t;

endpackage

### design/ogru_if.sv
// Valid/ready channel interfaces for requests and results.
// Depends on ogru_pkg.
interface ogru_in_if;
  import ogru_pkg::*;

  logic   valid;
  logic   ready;
  cmd_t   command;
  coord_t start_x;
  coord_t start_y;
  coord_t end_x;
  coord_t end_y;
  logic   hit;
  cell_t  write_value;

  modport source (output valid, command, start_x, start_y, end_x, end_y, hit, write_value,
                  input ready);
  modport sink (input valid, command, start_x, start_y, end_x, end_y, hit, write_value,
                output ready);
endinterface

interface ogru_out_if;
  import ogru_pkg::*;

  logic  valid;
  logic  ready;
  cell_t cell_value;
  walk_t cells_walked;
  logic  out_of_grid;

  modport source (output valid, cell_value, cells_walked, out_of_grid, input ready);
  modport sink (input valid, cell_value, cells_walked, out_of_grid, output ready);
endinterface

### design/ogru_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ogru_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/occupancy_grid_ray_update.sv
// Occupancy grid ray update. Depends on ogru_pkg, ogru_if, ogru_ram, assert_macros.svh.
// After reset a clearing pass writes 5 to every cell; no request is taken meanwhile. A read
// or write touches one cell, and an unused command goes straight to the result. A trace
// visits each line point, with a read-modify-write of the single RAM for each point inside
// the grid, and a hit adds the same for the 16 cells of the 4x4 hit square. One request
// at a time; the next is taken in the cycle after the result is loaded, even while it waits.
module occupancy_grid_ray_update #(
  parameter int GRID_W = ogru_pkg::GRID_W_DEF,
  parameter int GRID_H = ogru_pkg::GRID_H_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  ogru_in_if.sink    in_req,
  ogru_out_if.source out_rsp
);
  import ogru_pkg::*;
  `include "assert_macros.svh"

  localparam int DEPTH  = GRID_W * GRID_H;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int XW     = $clog2(GRID_W);
  localparam int YW     = $clog2(GRID_H);

  typedef logic signed [COORD_W:0]   pt_t;
  typedef logic signed [COORD_W+1:0] err_t;
  typedef logic [ADDR_W-1:0]         addr_t;

  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;
  pt_t    cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  pt_t    end_x_r, end_x_nxt, end_y_r, end_y_nxt;
  err_t   dx_r, dx_nxt, dy_r, dy_nxt, err_r, err_nxt;
  logic   sx_neg_r, sx_neg_nxt, sy_neg_r, sy_neg_nxt;
  logic   hit_r, hit_nxt;
  cell_t  wval_r, wval_nxt;
  walk_t  cnt_r, cnt_nxt;
  logic [3:0] mark_r, mark_nxt;
  logic   outside_r, outside_nxt;
  cell_t  value_r, value_nxt;
  addr_t  addr_r, addr_nxt;
  logic   ingrid_r, ingrid_nxt;
  addr_t  clr_r, clr_nxt;
  logic   out_valid_r, out_valid_nxt;
  cell_t  out_value_r, out_value_nxt;
  walk_t  out_walk_r, out_walk_nxt;
  logic   out_outside_r, out_outside_nxt;

  logic   accept, at_end, adv_done, advance, step_x, step_y, load_out;
  logic   ingrid_c;
  addr_t  addr_c;
  logic [3:0] mk_idx;
  pt_t    mk_x, mk_y;
  err_t   diff_x, diff_y, adx, ady;
  cell_t  lowered, raised;
  logic [CELL_W:0] raise_sum;

  logic   ram_we, ram_re;
  addr_t  ram_waddr;
  cell_t  ram_wdata, ram_rdata;

  ogru_ram #(.WIDTH(CELL_W), .DEPTH(DEPTH)) u_grid (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (addr_r),
    .rdata (ram_rdata)
  );

  assign in_req.ready         = (state_r == ST_IDLE);
  assign accept               = in_req.valid && in_req.ready;
  assign out_rsp.valid        = out_valid_r;
  assign out_rsp.cell_value   = out_value_r;
  assign out_rsp.cells_walked = out_walk_r;
  assign out_rsp.out_of_grid  = out_outside_r;

  // shared address unit: bounds check and x*GRID_H+y
  assign ingrid_c = !cur_x_r[COORD_W] && !cur_y_r[COORD_W] &&
                    (cur_x_r < pt_t'(GRID_W)) && (cur_y_r < pt_t'(GRID_H));
  assign addr_c   = addr_t'(addr_t'(cur_x_r[XW-1:0]) * addr_t'(GRID_H)) +
                    addr_t'(cur_y_r[YW-1:0]);

  // Bresenham step
  assign at_end = (cur_x_r == end_x_r) && (cur_y_r == end_y_r);
  assign step_x = err_r > -dx_r;
  assign step_y = err_r < dy_r;

  assign mk_idx = (phase_r == PH_TRACE) ? 4'd0 : mark_r + 4'd1;
  assign mk_x   = end_x_r + pt_t'({1'b0, mk_idx[3:2]}) - pt_t'(1);
  assign mk_y   = end_y_r + pt_t'({1'b0, mk_idx[1:0]}) - pt_t'(1);

  assign lowered   = (ram_rdata == CELL_PROTECTED || ram_rdata == '0) ? ram_rdata
                                                                      : ram_rdata - 4'd1;
  assign raise_sum = {1'b0, ram_rdata} + {1'b0, MARK_ADD};
  assign raised    = (raise_sum > {1'b0, MARK_CAP}) ? MARK_CAP : raise_sum[CELL_W-1:0];

  assign diff_x = err_t'(in_req.end_x) - err_t'(in_req.start_x);
  assign diff_y = err_t'(in_req.end_y) - err_t'(in_req.start_y);
  assign adx    = diff_x[COORD_W+1] ? -diff_x : diff_x;
  assign ady    = diff_y[COORD_W+1] ? -diff_y : diff_y;

  always_comb begin
    case (phase_r)
      PH_TRACE: adv_done = at_end && !hit_r;
      PH_MARK:  adv_done = (mark_r == 4'hF);
      default:  adv_done = 1'b1;
    endcase
  end

  assign advance  = ((state_r == ST_ACCESS) && !(ingrid_r && phase_r != PH_WRITE)) ||
                    (state_r == ST_UPDATE);
  assign load_out = (state_r == ST_DONE) && (!out_valid_r || out_rsp.ready);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_r == addr_t'(DEPTH - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          if (in_req.command inside {CMD_TRACE, CMD_READ, CMD_WRITE}) state_nxt = ST_ADDR;
          else state_nxt = ST_DONE;
        end
      end
      ST_ADDR: state_nxt = ST_ACCESS;
      ST_ACCESS: begin
        if (ingrid_r && phase_r != PH_WRITE) state_nxt = ST_UPDATE;
        else state_nxt = adv_done ? ST_DONE : ST_ADDR;
      end
      ST_UPDATE: state_nxt = adv_done ? ST_DONE : ST_ADDR;
      ST_DONE: begin
        if (load_out) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // RAM controls
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr_r;
    ram_wdata = wval_r;
    ram_re    = (state_r == ST_ACCESS) && ingrid_r && (phase_r != PH_WRITE);
    case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = CELL_RESET;
      end
      ST_ACCESS: ram_we = ingrid_r && (phase_r == PH_WRITE);
      ST_UPDATE: begin
        ram_we    = (phase_r == PH_TRACE) || (phase_r == PH_MARK);
        ram_wdata = (phase_r == PH_TRACE) ? lowered : raised;
      end
      default: ;
    endcase
  end

  // datapath
  always_comb begin
    phase_nxt       = phase_r;
    cur_x_nxt       = cur_x_r;
    cur_y_nxt       = cur_y_r;
    end_x_nxt       = end_x_r;
    end_y_nxt       = end_y_r;
    dx_nxt          = dx_r;
    dy_nxt          = dy_r;
    err_nxt         = err_r;
    sx_neg_nxt      = sx_neg_r;
    sy_neg_nxt      = sy_neg_r;
    hit_nxt         = hit_r;
    wval_nxt        = wval_r;
    cnt_nxt         = cnt_r;
    mark_nxt        = mark_r;
    outside_nxt     = outside_r;
    value_nxt       = value_r;
    addr_nxt        = addr_r;
    ingrid_nxt      = ingrid_r;
    clr_nxt         = clr_r;
    out_valid_nxt   = out_valid_r && !out_rsp.ready;
    out_value_nxt   = out_value_r;
    out_walk_nxt    = out_walk_r;
    out_outside_nxt = out_outside_r;

    if (state_r == ST_CLEAR) clr_nxt = clr_r + addr_t'(1);

    if (accept) begin
      cur_x_nxt   = pt_t'(in_req.start_x);
      cur_y_nxt   = pt_t'(in_req.start_y);
      end_x_nxt   = pt_t'(in_req.end_x);
      end_y_nxt   = pt_t'(in_req.end_y);
      dx_nxt      = adx;
      dy_nxt      = ady;
      err_nxt     = (adx > ady) ? (adx >>> 1) : -(ady >>> 1);
      sx_neg_nxt  = diff_x[COORD_W+1] || (diff_x == '0);
      sy_neg_nxt  = diff_y[COORD_W+1] || (diff_y == '0);
      hit_nxt     = in_req.hit;
      wval_nxt    = in_req.write_value;
      cnt_nxt     = '0;
      mark_nxt    = '0;
      outside_nxt = 1'b0;
      value_nxt   = '0;
      case (in_req.command)
        CMD_TRACE: phase_nxt = PH_TRACE;
        CMD_READ:  phase_nxt = PH_READ;
        default:   phase_nxt = PH_WRITE;
      endcase
    end

    if (state_r == ST_ADDR) begin
      addr_nxt   = addr_c;
      ingrid_nxt = ingrid_c;
    end

    if (state_r == ST_ACCESS && !ingrid_r) outside_nxt = 1'b1;

    if (state_r == ST_UPDATE && phase_r == PH_READ) value_nxt = ram_rdata;

    if (advance) begin
      case (phase_r)
        PH_TRACE: begin
          cnt_nxt = cnt_r + walk_t'(1);
          if (at_end) begin
            phase_nxt = PH_MARK;
            mark_nxt  = '0;
            cur_x_nxt = mk_x;
            cur_y_nxt = mk_y;
          end else begin
            err_nxt = err_r - (step_x ? dy_r : '0) + (step_y ? dx_r : '0);
            if (step_x) cur_x_nxt = sx_neg_r ? cur_x_r - pt_t'(1) : cur_x_r + pt_t'(1);
            if (step_y) cur_y_nxt = sy_neg_r ? cur_y_r - pt_t'(1) : cur_y_r + pt_t'(1);
          end
        end
        PH_MARK: begin
          mark_nxt  = mk_idx;
          cur_x_nxt = mk_x;
          cur_y_nxt = mk_y;
        end
        default: ;
      endcase
    end

    if (load_out) begin
      out_valid_nxt   = 1'b1;
      out_value_nxt   = value_r;
      out_walk_nxt    = cnt_r;
      out_outside_nxt = outside_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    phase_r       <= phase_nxt;
    cur_x_r       <= cur_x_nxt;
    cur_y_r       <= cur_y_nxt;
    end_x_r       <= end_x_nxt;
    end_y_r       <= end_y_nxt;
    dx_r          <= dx_nxt;
    dy_r          <= dy_nxt;
    err_r         <= err_nxt;
    sx_neg_r      <= sx_neg_nxt;
    sy_neg_r      <= sy_neg_nxt;
    hit_r         <= hit_nxt;
    wval_r        <= wval_nxt;
    mark_r        <= mark_nxt;
    outside_r     <= outside_nxt;
    value_r       <= value_nxt;
    addr_r        <= addr_nxt;
    ingrid_r      <= ingrid_nxt;
    out_value_r   <= out_value_nxt;
    out_walk_r    <= out_walk_nxt;
    out_outside_r <= out_outside_nxt;
  end

  `ASSERT_CLK(a_grid_write_in_bounds, (ram_we && state_r != ST_CLEAR) |-> ingrid_r, "grid write outside the grid")
  `ASSERT_CLK(a_busy_after_accept, accept |=> (state_r != ST_IDLE && state_r != ST_CLEAR), "no work after accepted request")
  `ASSERT_CLK(a_result_from_done, (out_valid_r && !$past(out_valid_r)) |-> $past(state_r == ST_DONE), "result loaded outside DONE")
  `ASSERT_NEVER(a_walk_bound, cnt_r > MAX_WALK, "walked count beyond line length bound")

endmodule

### bench/occupancy_grid_ray_update_test.sv
// Self-checking bench for occupancy_grid_ray_update: directed and random grid commands,
// results compared against an in-bench occupancy map model with random backpressure.
// Depends on ogru_pkg, ogru_if and the RTL of the block.
module occupancy_grid_ray_update_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ogru_pkg::*;

  localparam int GRID_W = GRID_W_DEF;
  localparam int GRID_H = GRID_H_DEF;
  localparam cmd_t CMD_NONE = 2'd3;

  typedef struct packed {
    logic   drain;
    cmd_t   command;
    coord_t sx;
    coord_t sy;
    coord_t ex;
    coord_t ey;
    logic   hit;
    cell_t  wval;
  } grid_cmd_t;

  typedef struct packed {
    cell_t cell_value;
    walk_t cells_walked;
    logic  out_of_grid;
  } grid_rsp_t;

  logic clk;
  logic rst_n;

  ogru_in_if  req_ch ();
  ogru_out_if rsp_ch ();

  occupancy_grid_ray_update #(
    .GRID_W(GRID_W),
    .GRID_H(GRID_H)
  ) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (req_ch),
    .out_rsp(rsp_ch)
  );

  cell_t     occ_map [GRID_W*GRID_H];
  logic      hit_outside;
  grid_cmd_t pending_cmds[$];
  grid_rsp_t predicted_rsps[$];
  grid_cmd_t cur_cmd;
  grid_rsp_t want;
  int        pause_left;
  int        sent_count;
  int        taken_count;
  int        stall_left;
  int        hold_left;
  bit        long_hold_done;
  int        error_count;

  // ---------------- occupancy map model ----------------
  function automatic bit on_map(int x, int y);
    return x >= 0 && y >= 0 && x < GRID_W && y < GRID_H;
  endfunction

  function automatic void lower_cell(int x, int y);
    int i;
    if (!on_map(x, y)) begin
      hit_outside = 1'b1;
      return;
    end
    i = x * GRID_H + y;
    if (occ_map[i] != CELL_PROTECTED && occ_map[i] != 4'd0)
      occ_map[i] = occ_map[i] - 4'd1;
  endfunction

  function automatic void raise_cell(int x, int y);
    int i;
    int v;
    if (!on_map(x, y)) begin
      hit_outside = 1'b1;
      return;
    end
    i = x * GRID_H + y;
    v = int'(occ_map[i]) + int'(MARK_ADD);
    if (v > int'(MARK_CAP))
      v = int'(MARK_CAP);
    occ_map[i] = cell_t'(v);
  endfunction

  function automatic grid_rsp_t apply_grid_command(grid_cmd_t c);
    grid_rsp_t r;
    int x0, y0, x1, y1, dx, dy, stx, sty, err, e2, n;
    r = '0;
    hit_outside = 1'b0;
    x0 = int'($signed(c.sx));
    y0 = int'($signed(c.sy));
    x1 = int'($signed(c.ex));
    y1 = int'($signed(c.ey));
    case (c.command)
      CMD_TRACE: begin
        dx = (x1 > x0) ? x1 - x0 : x0 - x1;
        dy = (y1 > y0) ? y1 - y0 : y0 - y1;
        stx = (x0 < x1) ? 1 : -1;
        sty = (y0 < y1) ? 1 : -1;
        err = ((dx > dy) ? dx : -dy) / 2;
        n = 0;
        while (1'b1) begin
          lower_cell(x0, y0);
          n++;
          if (x0 == x1 && y0 == y1)
            break;
          e2 = err;
          if (e2 > -dx) begin
            err -= dy;
            x0 += stx;
          end
          if (e2 < dy) begin
            err += dx;
            y0 += sty;
          end
        end
        r.cells_walked = walk_t'(n);
        if (c.hit) begin
          for (int ix = x1 - 1; ix <= x1 + 2; ix++)
            for (int iy = y1 - 1; iy <= y1 + 2; iy++)
              raise_cell(ix, iy);
        end
      end
      CMD_READ: begin
        if (on_map(x0, y0))
          r.cell_value = occ_map[x0 * GRID_H + y0];
        else
          hit_outside = 1'b1;
      end
      CMD_WRITE: begin
        if (on_map(x0, y0))
          occ_map[x0 * GRID_H + y0] = c.wval;
        else
          hit_outside = 1'b1;
      end
      default: ;
    endcase
    r.out_of_grid = hit_outside;
    return r;
  endfunction

  // ---------------- stimulus helpers ----------------
  function automatic int draw_pause(int k);
    if ((k / 60) % 4 == 3)
      return 0;
    return int'($urandom_range(0, 8));
  endfunction

  function automatic int clip12(int v);
    if (v < -2048)
      return -2048;
    if (v > 2047)
      return 2047;
    return v;
  endfunction

  // mostly a few small hot windows so cells get revisited, plus edges and full range
  function automatic int pick_coord(int limit);
    int base;
    case ($urandom_range(0, 19))
      0: return int'($urandom_range(0, 4095)) - 2048;
      1, 2: return limit - 4 + int'($urandom_range(0, 7));
      3, 4: return int'($urandom_range(0, 7)) - 4;
      default: begin
        case ($urandom_range(0, 2))
          0: base = 0;
          1: base = limit / 2;
          default: base = limit - 12;
        endcase
        return base + int'($urandom_range(0, 11));
      end
    endcase
  endfunction

  function automatic cell_t pick_wval();
    case ($urandom_range(0, 5))
      0: return CELL_PROTECTED;
      1: return cell_t'(0);
      2: return cell_t'(9);
      default: return cell_t'($urandom_range(0, 15));
    endcase
  endfunction

  task automatic queue_cmd(cmd_t c, int sx, int sy, int ex, int ey, logic h, cell_t wv);
    grid_cmd_t g;
    g.drain = 1'b0;
    g.command = c;
    g.sx = coord_t'(clip12(sx));
    g.sy = coord_t'(clip12(sy));
    g.ex = coord_t'(clip12(ex));
    g.ey = coord_t'(clip12(ey));
    g.hit = h;
    g.wval = wv;
    pending_cmds.push_back(g);
  endtask

  task automatic queue_drain();
    grid_cmd_t g;
    g = '0;
    g.drain = 1'b1;
    pending_cmds.push_back(g);
  endtask

  // ---------------- clock and reset ----------------
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.command = CMD_TRACE;
    req_ch.start_x = '0;
    req_ch.start_y = '0;
    req_ch.end_x = '0;
    req_ch.end_y = '0;
    req_ch.hit = 1'b0;
    req_ch.write_value = '0;
    rsp_ch.ready = 1'b0;
    foreach (occ_map[i])
      occ_map[i] = CELL_RESET;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
  end

  // ---------------- request driver ----------------
  always @(posedge clk) begin
    if (!rst_n) begin
      req_ch.valid <= 1'b0;
      pause_left <= 0;
      sent_count = 0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        predicted_rsps.push_back(apply_grid_command(cur_cmd));
        sent_count++;
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (pause_left != 0) begin
          req_ch.valid <= 1'b0;
          pause_left <= pause_left - 1;
        end else if (pending_cmds.size() != 0 && pending_cmds[0].drain) begin
          req_ch.valid <= 1'b0;
          if (predicted_rsps.size() == 0)
            void'(pending_cmds.pop_front());
        end else if (pending_cmds.size() != 0) begin
          cur_cmd = pending_cmds.pop_front();
          req_ch.valid <= 1'b1;
          req_ch.command <= cur_cmd.command;
          req_ch.start_x <= cur_cmd.sx;
          req_ch.start_y <= cur_cmd.sy;
          req_ch.end_x <= cur_cmd.ex;
          req_ch.end_y <= cur_cmd.ey;
          req_ch.hit <= cur_cmd.hit;
          req_ch.write_value <= cur_cmd.wval;
          pause_left <= draw_pause(sent_count);
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------- result monitor and ready control ----------------
  always @(posedge clk) begin
    if (!rst_n) begin
      rsp_ch.ready <= 1'b0;
      taken_count = 0;
      stall_left = 0;
      hold_left = 0;
      long_hold_done = 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        taken_count++;
        if (predicted_rsps.size() == 0) begin
          error_count++;
          if (error_count <= 10)
            $display("[%0t] unexpected result: cell=%0d walked=%0d oog=%0b", $realtime,
                     rsp_ch.cell_value, rsp_ch.cells_walked, rsp_ch.out_of_grid);
        end else begin
          want = predicted_rsps.pop_front();
          if (rsp_ch.cell_value !== want.cell_value ||
              rsp_ch.cells_walked !== want.cells_walked ||
              rsp_ch.out_of_grid !== want.out_of_grid) begin
            error_count++;
            if (error_count <= 10)
              $display("[%0t] result %0d mismatch: exp cell=%0d walked=%0d oog=%0b, got cell=%0d walked=%0d oog=%0b",
                       $realtime, taken_count, want.cell_value, want.cells_walked,
                       want.out_of_grid, rsp_ch.cell_value, rsp_ch.cells_walked,
                       rsp_ch.out_of_grid);
          end
        end
        stall_left = draw_pause(taken_count);
      end
      // one long back-pressure window so the block fills and stalls its input
      if (!long_hold_done && taken_count >= 600) begin
        long_hold_done = 1'b1;
        hold_left = 400;
      end
      if (hold_left != 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // ---------------- stimulus and end of test ----------------
  initial begin
    int sx, sy, ex, ey;
    error_count = 0;

    // protected cell, mark over protected cell, floor, reads and writes off the map
    queue_cmd(CMD_READ, 0, 0, 0, 0, 1'b0, 4'd0);
    queue_cmd(CMD_WRITE, 0, 0, 0, 0, 1'b0, CELL_PROTECTED);
    queue_cmd(CMD_TRACE, 0, 0, 3, 0, 1'b0, 4'd0);
    queue_cmd(CMD_READ, 0, 0, 0, 0, 1'b0, 4'd0);
    queue_cmd(CMD_TRACE, 5, 5, 0, 0, 1'b1, 4'd0);
    queue_cmd(CMD_READ, 0, 0, 0, 0, 1'b0, 4'd0);
    queue_cmd(CMD_READ, 1, 1, 0, 0, 1'b0, 4'd0);
    queue_cmd(CMD_WRITE, GRID_W - 1, GRID_H - 1, 0, 0, 1'b0, 4'd0);
    queue_cmd(CMD_TRACE, GRID_W - 1, GRID_H - 1, GRID_W - 1, GRID_H - 1, 1'b0, 4'd0);
    queue_cmd(CMD_READ, GRID_W - 1, GRID_H - 1, 0, 0, 1'b0, 4'd0);
    queue_cmd(CMD_READ, -1, 0, 0, 0, 1'b0, 4'd0);
    queue_cmd(CMD_READ, GRID_W, 5, 0, 0, 1'b0, 4'd0);
    queue_cmd(CMD_READ, 5, GRID_H, 0, 0, 1'b0, 4'd0);
    queue_cmd(CMD_READ, -2048, 2047, 0, 0, 1'b0, 4'd0);
    queue_cmd(CMD_WRITE, 2047, -2048, 0, 0, 1'b0, 4'd7);
    queue_cmd(CMD_NONE, -1, -1, -1, -1, 1'b1, 4'd15);
    queue_cmd(CMD_TRACE, -2048, -2048, 2047, 2047, 1'b1, 4'd0);
    queue_cmd(CMD_TRACE, 10, -5, 10, 20, 1'b0, 4'd0);
    queue_cmd(CMD_TRACE, 3, 3, 5, 40, 1'b1, 4'd0);
    queue_cmd(CMD_WRITE, 100, 100, 0, 0, 1'b0, 4'd9);
    queue_cmd(CMD_TRACE, 100, 100, 100, 100, 1'b1, 4'd0);
    queue_cmd(CMD_READ, 100, 100, 0, 0, 1'b0, 4'd0);
    queue_cmd(CMD_TRACE, 2047, -2048, -2048, 2047, 1'b0, 4'd0);
    queue_cmd(CMD_TRACE, GRID_W - 1, 0, GRID_W - 40, GRID_H - 1, 1'b1, 4'd0);
    queue_cmd(CMD_TRACE, GRID_W - 1, GRID_H - 1, GRID_W - 1, GRID_H - 1, 1'b1, 4'd0);

    for (int k = 0; k < 1400; k++) begin
      if (k == 500 || k == 1000)
        queue_drain();
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7, 8, 9: begin
          sx = pick_coord(GRID_W);
          sy = pick_coord(GRID_H);
          if ($urandom_range(0, 99) == 0) begin
            ex = int'($urandom_range(0, 4095)) - 2048;
            ey = int'($urandom_range(0, 4095)) - 2048;
          end else begin
            ex = sx + int'($urandom_range(0, 48)) - 24;
            ey = sy + int'($urandom_range(0, 48)) - 24;
          end
          queue_cmd(CMD_TRACE, sx, sy, ex, ey, 1'($urandom_range(0, 1)),
                    cell_t'($urandom_range(0, 15)));
        end
        10, 11, 12, 13, 14:
          queue_cmd(CMD_READ, pick_coord(GRID_W), pick_coord(GRID_H),
                    int'($urandom_range(0, 4095)) - 2048, int'($urandom_range(0, 4095)) - 2048,
                    1'($urandom_range(0, 1)), cell_t'($urandom_range(0, 15)));
        15, 16, 17, 18:
          queue_cmd(CMD_WRITE, pick_coord(GRID_W), pick_coord(GRID_H),
                    int'($urandom_range(0, 4095)) - 2048, int'($urandom_range(0, 4095)) - 2048,
                    1'($urandom_range(0, 1)), pick_wval());
        default:
          queue_cmd(CMD_NONE, int'($urandom_range(0, 4095)) - 2048,
                    int'($urandom_range(0, 4095)) - 2048, int'($urandom_range(0, 4095)) - 2048,
                    int'($urandom_range(0, 4095)) - 2048, 1'($urandom_range(0, 1)),
                    cell_t'($urandom_range(0, 15)));
      endcase
    end

    while (pending_cmds.size() != 0 || req_ch.valid !== 1'b0)
      @(posedge clk);
    while (predicted_rsps.size() != 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
    if (error_count == 0)
      $display("occupancy_grid_ray_update_test: PASS");
    else
      $display("occupancy_grid_ray_update_test: FAIL");
    $finish;
  end

  // clearing pass plus worst-case traffic, taken several times over
  initial begin
    #25_000_000;
    $display("occupancy_grid_ray_update_test: FAIL");
    $finish;
  end

endmodule

### sim.f
+incdir+design
design/ogru_pkg.sv
design/ogru_if.sv
design/ogru_ram.sv
design/occupancy_grid_ray_update.sv
bench/occupancy_grid_ray_update_test.sv
